// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define WUF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// An implication: when pre holds, post must hold in the same cycle.
`define WUF_ASSERT_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

`endif

// File: sv/wuf_pkg.sv
// ----------------------------------------------------------------------------
// wuf_pkg
// Types, constants and mod-3 helpers shared by the union-find block.
// ----------------------------------------------------------------------------
`default_nettype none

package wuf_pkg;

    // Field widths of one item.
    localparam int unsigned NODE_W      = 10;
    localparam int unsigned WEIGHT_W    = 2;
    localparam int unsigned IN_TDATA_W  = 24;
    localparam int unsigned OUT_TDATA_W = 8;

    // Operation codes carried in tuser.
    localparam logic FUNC_RELATE = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    // Answer code for nodes in different trees.
    localparam logic [WEIGHT_W-1:0] ANS_UNKNOWN = 2'd3;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_P1_WALK,
        ST_P2_WALK,
        ST_DONE
    } wuf_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;   // write one entry of the reset sweep
        logic accept;     // latch a new item and read node a
        logic p1_step;    // first pass: add weight, move to parent
        logic p1_end;     // first pass hit the root: restart at the start node
        logic p2_step;    // second pass: hang node on the root
        logic find_done;  // one find is complete
        logic out_load;   // move the answer into the output register
    } wuf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;   // sweep is at its last entry
        logic in_ok;      // incoming item has both nodes in range
        logic in_query;   // incoming item is a query
        logic is_query;   // latched item is a query
        logic at_root;    // node read in the first pass is its own parent
        logic walk_done;  // second pass cursor reached the root
        logic phase_b;    // working on the find of node b
        logic out_free;   // output register can take an answer
    } wuf_sts_t;

    // Sum of two values in 0..2, mod 3.
    function automatic logic [WEIGHT_W-1:0] mod3_add(input logic [WEIGHT_W-1:0] x,
                                                     input logic [WEIGHT_W-1:0] y);
        logic [WEIGHT_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= 3'd3) begin
            s = s - 3'd3;
        end
        return s[WEIGHT_W-1:0];
    endfunction

    // Difference of two values in 0..2, mod 3.
    function automatic logic [WEIGHT_W-1:0] mod3_sub(input logic [WEIGHT_W-1:0] x,
                                                     input logic [WEIGHT_W-1:0] y);
        logic [WEIGHT_W-1:0] n;
        n = (y == 2'd0) ? 2'd0 : 2'd3 - y;
        return mod3_add(x, n);
    endfunction

endpackage

`default_nettype wire

// File: sv/wuf_ram.sv
// ----------------------------------------------------------------------------
// wuf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module wuf_ram #(
    parameter int unsigned WIDTH = 12,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: sv/wuf_dpath.sv
// ----------------------------------------------------------------------------
// wuf_dpath
// Datapath: node table, walk cursor and sums, root registers, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wuf_dpath
    import wuf_pkg::*;
#(
    parameter int unsigned NODES = 1024
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire wuf_cmd_t               cmd,
    output wuf_sts_t                    sts,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic [0:0]             s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    localparam int unsigned AW = $clog2(NODES);
    localparam int unsigned MW = AW + WEIGHT_W;

    // Incoming fields.
    logic [NODE_W-1:0]   in_a;
    logic [NODE_W-1:0]   in_b;
    logic [WEIGHT_W-1:0] in_rel;
    logic [WEIGHT_W-1:0] in_rel_m3;

    assign in_a      = s_tdata[NODE_W-1:0];
    assign in_b      = s_tdata[2*NODE_W-1:NODE_W];
    assign in_rel    = s_tdata[2*NODE_W+WEIGHT_W-1:2*NODE_W];
    assign in_rel_m3 = (in_rel == 2'd3) ? 2'd0 : in_rel;

    // Registers.
    logic [AW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [WEIGHT_W-1:0] out_ans_reg;
    logic                func_reg;
    logic [AW-1:0]       a_reg, b_reg;
    logic [WEIGHT_W-1:0] rel_reg;
    logic                phase_reg;
    logic [AW-1:0]       cur_reg, root_reg, ra_reg;
    logic [WEIGHT_W-1:0] sum_reg, tot_reg, wa_reg, ans_reg;

    // Table port.
    logic                ram_wr_en, ram_rd_en;
    logic [AW-1:0]       ram_wr_addr, ram_rd_addr;
    logic [MW-1:0]       ram_wr_data, ram_rd_data;
    logic [AW-1:0]       rd_parent;
    logic [WEIGHT_W-1:0] rd_weight;
    logic [AW-1:0]       start_node;

    assign rd_parent  = ram_rd_data[MW-1:WEIGHT_W];
    assign rd_weight  = ram_rd_data[WEIGHT_W-1:0];
    assign start_node = phase_reg ? b_reg : a_reg;

    wuf_ram #(
        .WIDTH (MW),
        .DEPTH (NODES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Read address: node a on accept, then the walk nodes, then node b.
    always_comb begin
        ram_rd_en   = 1'b0;
        ram_rd_addr = rd_parent;
        if (cmd.accept) begin
            ram_rd_en   = sts.in_ok;
            ram_rd_addr = AW'(in_a);
        end else if (cmd.p1_step || cmd.p2_step) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = rd_parent;
        end else if (cmd.p1_end) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = start_node;
        end else if (cmd.find_done && !phase_reg) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = b_reg;
        end
    end

    // Write port: reset sweep, path compression, or the link of two roots.
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = cur_reg;
        ram_wr_data = {cur_reg, 2'd0};
        if (cmd.clr_step) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_reg;
            ram_wr_data = {clr_cnt_reg, 2'd0};
        end else if (cmd.p2_step) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cur_reg;
            ram_wr_data = {root_reg, sum_reg};
        end else if (cmd.find_done && phase_reg && func_reg == FUNC_RELATE) begin
            ram_wr_en   = (ra_reg != root_reg);
            ram_wr_addr = ra_reg;
            ram_wr_data = {root_reg, mod3_add(rel_reg, mod3_sub(tot_reg, wa_reg))};
        end
    end

    // Control registers: sweep counter and output valid.
    always_comb begin
        clr_cnt_next   = cmd.clr_step ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Walk registers.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            func_reg  <= s_tuser[0];
            a_reg     <= AW'(in_a);
            b_reg     <= AW'(in_b);
            rel_reg   <= in_rel_m3;
            phase_reg <= 1'b0;
            cur_reg   <= AW'(in_a);
            sum_reg   <= 2'd0;
            ans_reg   <= ANS_UNKNOWN;
        end
        if (cmd.p1_step) begin
            sum_reg <= mod3_add(sum_reg, rd_weight);
            cur_reg <= rd_parent;
        end
        if (cmd.p1_end) begin
            root_reg <= cur_reg;
            tot_reg  <= sum_reg;
            cur_reg  <= start_node;
        end
        if (cmd.p2_step) begin
            sum_reg <= mod3_sub(sum_reg, rd_weight);
            cur_reg <= rd_parent;
        end
        if (cmd.find_done) begin
            if (!phase_reg) begin
                wa_reg    <= tot_reg;
                ra_reg    <= root_reg;
                phase_reg <= 1'b1;
                cur_reg   <= b_reg;
                sum_reg   <= 2'd0;
            end else if (ra_reg == root_reg) begin
                ans_reg <= mod3_sub(wa_reg, tot_reg);
            end else begin
                ans_reg <= ANS_UNKNOWN;
            end
        end
        if (cmd.out_load) begin
            out_ans_reg <= ans_reg;
        end
    end

    // Status to the controller.
    always_comb begin
        sts.clr_last  = (clr_cnt_reg == AW'(NODES - 1));
        sts.in_ok     = (32'(in_a) < 32'(NODES)) && (32'(in_b) < 32'(NODES));
        sts.in_query  = (s_tuser[0] == FUNC_QUERY);
        sts.is_query  = (func_reg == FUNC_QUERY);
        sts.at_root   = (rd_parent == cur_reg);
        sts.walk_done = (cur_reg == root_reg);
        sts.phase_b   = phase_reg;
        sts.out_free  = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - WEIGHT_W){1'b0}}, out_ans_reg};

endmodule

`default_nettype wire

// File: sv/wuf_ctrl.sv
// ----------------------------------------------------------------------------
// wuf_ctrl
// Controller: reset sweep, two-pass find of both nodes, link and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module wuf_ctrl
    import wuf_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire wuf_sts_t sts,
    output wuf_cmd_t      cmd
);

    wuf_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (sts.in_ok) begin
                        state_next = ST_P1_WALK;
                    end else if (sts.in_query) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_P1_WALK: begin
                if (sts.at_root) begin
                    cmd.p1_end = 1'b1;
                    state_next = ST_P2_WALK;
                end else begin
                    cmd.p1_step = 1'b1;
                end
            end
            ST_P2_WALK: begin
                if (sts.walk_done) begin
                    cmd.find_done = 1'b1;
                    if (!sts.phase_b) begin
                        state_next = ST_P1_WALK;
                    end else if (sts.is_query) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    cmd.p2_step = 1'b1;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/weighted_union_find_mod3.sv
// An item in range runs a find of node a, then a find of node b;
// one find takes one table read per node on the path, twice (sum pass, then rewrite).
// The block takes one item at a time and is not ready until it is through with the last;
// a node out of range skips the finds: a relate is dropped, a query answers unknown.
// Reset: synchronous, active low; afterwards a sweep loads the table
// (every node its own root, weight zero) and the input stays not ready until it ends.
// ----------------------------------------------------------------------------
// weighted_union_find_mod3
// Disjoint-set forest with mod-3 link weights, path compression, relate and query.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module weighted_union_find_mod3
    import wuf_pkg::*;
#(
    parameter int unsigned NODES = 1024
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // node_a[9:0], node_b[19:10], relation[21:20]
    input  wire logic [0:0]             s_tuser,   // func[0]
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata    // answer[1:0]
);

    wuf_cmd_t cmd;
    wuf_sts_t sts;

    wuf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wuf_dpath #(
        .NODES (NODES)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // The controller issues at most one datapath command per cycle.
    `WUF_ASSERT(a_one_cmd, ($onehot0(cmd)), "more than one datapath command")

    // An answer is loaded only when the output register can take it.
    `WUF_ASSERT_IMPLY(a_load_free, cmd.out_load, sts.out_free, "answer loaded over a waiting result")

    // A result appears only after an answer load.
    `WUF_ASSERT_IMPLY(a_valid_src, $rose(m_tvalid), $past(cmd.out_load), "result valid without a load")

    // No item is taken while the table sweep is running.
    `WUF_ASSERT_IMPLY(a_no_accept_clr, cmd.clr_step, !s_tready, "input ready during the table sweep")

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives relate and query items into the weighted union-find block. Bursty
// input and a stalling result channel exercise the handshakes. A software
// forest with path compression predicts every query answer, and each answer
// is checked in order.
// ----------------------------------------------------------------------------
module testbench;
    import wuf_pkg::*;

    localparam int unsigned TABLE_SIZE = 1024;
    localparam int unsigned RANDOM_ITEMS = 1650;

    // Predicts query answers from its own copy of the forest.
    class relation_scoreboard;
        bit [NODE_W-1:0]   parent [TABLE_SIZE];
        bit [WEIGHT_W-1:0] weight [TABLE_SIZE];
        bit [WEIGHT_W-1:0] answer_q[$];
        int errors;

        function new();
            for (int i = 0; i < TABLE_SIZE; i++) begin
                parent[i] = NODE_W'(i);
                weight[i] = '0;
            end
            errors = 0;
        endfunction

        // Walks to the root, then hangs every node on the path on the root.
        function bit [NODE_W-1:0] find_root(bit [NODE_W-1:0] x);
            bit [NODE_W-1:0] cur;
            bit [NODE_W-1:0] top;
            bit [NODE_W-1:0] nxt;
            int sum;
            int old;
            int steps;
            cur = x;
            sum = 0;
            steps = 0;
            while (parent[cur] != cur && steps < TABLE_SIZE) begin
                sum = (sum + weight[cur]) % 3;
                cur = parent[cur];
                steps++;
            end
            top = cur;
            cur = x;
            steps = 0;
            while (cur != top && steps < TABLE_SIZE) begin
                nxt = parent[cur];
                old = weight[cur];
                parent[cur] = top;
                weight[cur] = WEIGHT_W'(sum);
                sum = (sum + 3 - old) % 3;
                cur = nxt;
                steps++;
            end
            return top;
        endfunction

        // Applies one accepted item; a query leaves its answer in the queue.
        // Every 10-bit index lies inside the table, so no range check is needed.
        function void note_item(logic func, bit [NODE_W-1:0] a, bit [NODE_W-1:0] b,
                                bit [WEIGHT_W-1:0] rel);
            bit [NODE_W-1:0] ra;
            bit [NODE_W-1:0] rb;
            int r;
            r = rel % 3;
            ra = find_root(a);
            rb = find_root(b);
            if (func == FUNC_RELATE) begin
                if (ra != rb) begin
                    parent[ra] = rb;
                    weight[ra] = WEIGHT_W'((r + weight[b] + 3 - weight[a]) % 3);
                end
            end else if (ra != rb) begin
                answer_q.push_back(ANS_UNKNOWN);
            end else begin
                answer_q.push_back(WEIGHT_W'((weight[a] + 3 - weight[b]) % 3));
            end
        endfunction

        task report(string msg);
            $display("%0t ns: mismatch: %s", $realtime, msg);
            errors++;
        endtask

        // Compares one received answer with the oldest prediction.
        task check_answer(bit [WEIGHT_W-1:0] got);
            bit [WEIGHT_W-1:0] want;
            if (answer_q.size() == 0) begin
                report($sformatf("answer %0d arrived with none expected", got));
            end else begin
                want = answer_q.pop_front();
                if (got != want) begin
                    report($sformatf("answer %0d, expected %0d", got, want));
                end
            end
        endtask

        function int pending();
            return answer_q.size();
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // node_a[9:0], node_b[19:10], relation[21:20]
    logic [0:0]             s_tuser;   // func[0]
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // answer[1:0]

    relation_scoreboard sb;
    int burst_left;
    int rx_count;
    int rx_mode;

    weighted_union_find_mod3 dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock with a 2 ns period.
    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Hang guard, far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Sends one item, idling first when the current burst is used up.
    task send_item(logic func, bit [NODE_W-1:0] a, bit [NODE_W-1:0] b,
                   bit [WEIGHT_W-1:0] rel);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 20);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {2'b00, rel, b, a};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        sb.note_item(func, a, b, rel);
    endtask

    // Random item: mostly nodes from a narrow window so that trees grow and
    // queries land in the same tree, sometimes any node at all.
    task send_random(int base, int span);
        bit [NODE_W-1:0] a;
        bit [NODE_W-1:0] b;
        if ($urandom_range(0, 9) == 0) begin
            a = NODE_W'($urandom_range(0, TABLE_SIZE - 1));
            b = NODE_W'($urandom_range(0, TABLE_SIZE - 1));
        end else begin
            a = NODE_W'(base + $urandom_range(0, span - 1));
            b = NODE_W'(base + $urandom_range(0, span - 1));
        end
        send_item($urandom_range(0, 1) ? FUNC_QUERY : FUNC_RELATE, a, b,
                  WEIGHT_W'($urandom_range(0, 3)));
    endtask

    // Result side: checks each answer and stalls in changing patterns.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_count <= 0;
            rx_mode  <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                sb.check_answer(m_tdata[WEIGHT_W-1:0]);
            end
            rx_count <= rx_count + 1;
            if (rx_count[5:0] == 6'd63) begin
                rx_mode <= $urandom_range(0, 3);
            end
            case (rx_mode)
                0: begin
                    m_tready <= 1'b1;
                end
                1: begin
                    m_tready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    m_tready <= (rx_count[1:0] == 2'd0);
                end
                default: begin
                    m_tready <= (rx_count[4:0] >= 5'd24);
                end
            endcase
        end
    end

    // Reset, directed items, random items, then drain.
    initial begin
        int base;
        int span;
        int pick;
        sb = new();
        burst_left = 0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Same node, extreme nodes, and nodes in separate trees.
        send_item(FUNC_QUERY, 10'd0, 10'd0, 2'd0);
        send_item(FUNC_QUERY, 10'd1023, 10'd1023, 2'd3);
        send_item(FUNC_QUERY, 10'd0, 10'd1023, 2'd1);
        send_item(FUNC_RELATE, 10'd0, 10'd1023, 2'd2);
        send_item(FUNC_QUERY, 10'd0, 10'd1023, 2'd0);
        send_item(FUNC_QUERY, 10'd1023, 10'd0, 2'd2);
        // A relate between nodes already in one tree changes nothing.
        send_item(FUNC_RELATE, 10'd0, 10'd1023, 2'd1);
        send_item(FUNC_QUERY, 10'd0, 10'd1023, 2'd0);
        // Relation three wraps to zero.
        send_item(FUNC_RELATE, 10'd5, 10'd6, 2'd3);
        send_item(FUNC_QUERY, 10'd6, 10'd5, 2'd0);
        send_item(FUNC_RELATE, 10'd682, 10'd341, 2'd1);
        send_item(FUNC_QUERY, 10'd341, 10'd682, 2'd0);
        // A chain of roots hung one under the next, then compressed by queries.
        for (int k = 0; k < 8; k++) begin
            send_item(FUNC_RELATE, NODE_W'(100 + k), NODE_W'(101 + k), WEIGHT_W'(k % 3));
        end
        send_item(FUNC_QUERY, 10'd100, 10'd108, 2'd0);
        send_item(FUNC_QUERY, 10'd104, 10'd100, 2'd0);
        send_item(FUNC_RELATE, 10'd6, 10'd100, 2'd2);
        send_item(FUNC_QUERY, 10'd5, 10'd108, 2'd0);
        send_item(FUNC_QUERY, 10'd1023, 10'd5, 2'd0);

        // Random items; the node window moves every 40 items.
        base = 0;
        span = 16;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 40 == 0) begin
                pick = $urandom_range(0, 9);
                span = (pick < 3) ? 4 : (pick < 7) ? 16 : (pick < 9) ? 64 : TABLE_SIZE;
                base = $urandom_range(0, TABLE_SIZE - span);
            end
            send_random(base, span);
        end
        s_tvalid <= 1'b0;

        // Drain the outstanding answers, then watch for strays.
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (200) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
